@@ sv/mld_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mld_pkg: shared definitions for the mouse-look direction block
// Fixed-point limits, the CORDIC arctangent table and the microcode ROM.
// ----------------------------------------------------------------------------
package mld_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ITER_W       = $clog2(CORDIC_STEPS);
	localparam int PC_W         = 4;

	localparam logic [19:0]        STEP_LIMIT    = 20'd737280;
	localparam logic signed [21:0] YAW_HALF_TURN = 22'sd737280;
	localparam logic signed [21:0] YAW_FULL_TURN = 22'sd1474560;
	localparam logic signed [21:0] PITCH_LIMIT   = 22'sd364544;
	localparam logic signed [25:0] Z_QUARTER     = 26'sd5898240;
	localparam logic signed [25:0] Z_HALF        = 26'sd11796480;
	localparam logic signed [31:0] CORDIC_START  = 32'sd652032874;
	localparam logic [15:0]        SENS_RESET    = 16'd6554;
	localparam logic [15:0]        Q15_MAX       = 16'd32767;

	typedef enum logic [3:0] {
		OP_WAIT,
		OP_MUL,
		OP_STEP,
		OP_ANGLE,
		OP_LOAD,
		OP_ITER,
		OP_FLIP,
		OP_PROD,
		OP_DIRX,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		C_ALWAYS,
		C_INPUT,
		C_LOOP,
		C_OUT_FREE
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctrl_t;

	localparam logic [PC_W-1:0] PC_WAIT = 4'd0;
	localparam logic [PC_W-1:0] PC_MUL  = 4'd1;
	localparam logic [PC_W-1:0] PC_STEP = 4'd2;
	localparam logic [PC_W-1:0] PC_ANG  = 4'd3;
	localparam logic [PC_W-1:0] PC_LOAD = 4'd4;
	localparam logic [PC_W-1:0] PC_ITER = 4'd5;
	localparam logic [PC_W-1:0] PC_FLIP = 4'd6;
	localparam logic [PC_W-1:0] PC_PROD = 4'd7;
	localparam logic [PC_W-1:0] PC_DIRX = 4'd8;
	localparam logic [PC_W-1:0] PC_EMIT = 4'd9;

	function automatic logic signed [25:0] atan_deg(input logic [ITER_W-1:0] i);
		logic signed [25:0] r;
		unique case (i)
			4'd0:  r = 26'sd2949120;
			4'd1:  r = 26'sd1740967;
			4'd2:  r = 26'sd919879;
			4'd3:  r = 26'sd466945;
			4'd4:  r = 26'sd234379;
			4'd5:  r = 26'sd117304;
			4'd6:  r = 26'sd58666;
			4'd7:  r = 26'sd29335;
			4'd8:  r = 26'sd14668;
			4'd9:  r = 26'sd7334;
			4'd10: r = 26'sd3667;
			4'd11: r = 26'sd1833;
			4'd12: r = 26'sd917;
			4'd13: r = 26'sd458;
			4'd14: r = 26'sd229;
			4'd15: r = 26'sd115;
			default: r = 26'sd0;
		endcase
		return r;
	endfunction

	function automatic ctrl_t mld_rom(input logic [PC_W-1:0] pc);
		ctrl_t w;
		unique case (pc)
			PC_WAIT: w = '{OP_WAIT,  C_INPUT,    PC_MUL};
			PC_MUL:  w = '{OP_MUL,   C_ALWAYS,   PC_STEP};
			PC_STEP: w = '{OP_STEP,  C_ALWAYS,   PC_ANG};
			PC_ANG:  w = '{OP_ANGLE, C_ALWAYS,   PC_LOAD};
			PC_LOAD: w = '{OP_LOAD,  C_ALWAYS,   PC_ITER};
			PC_ITER: w = '{OP_ITER,  C_LOOP,     PC_ITER};
			PC_FLIP: w = '{OP_FLIP,  C_ALWAYS,   PC_PROD};
			PC_PROD: w = '{OP_PROD,  C_ALWAYS,   PC_DIRX};
			PC_DIRX: w = '{OP_DIRX,  C_ALWAYS,   PC_EMIT};
			PC_EMIT: w = '{OP_EMIT,  C_OUT_FREE, PC_WAIT};
			default: w = '{OP_WAIT,  C_ALWAYS,   PC_WAIT};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

@@ sv/mouse_look_direction.sv @@
// The sequencer takes a new item only once the previous one has passed the step
// and angle steps, the 16 iterations of the shared two-lane CORDIC loop and the
// product steps, and its result has been placed in the output register.
// A first item after reset is stored and gives no result.
// Reset clears the angles, the stored position and the sequencer at once.
`default_nettype none
// ----------------------------------------------------------------------------
// mouse_look_direction: camera look direction from cursor motion
// A microcoded sequencer turns cursor deltas into yaw and pitch updates and
// a unit direction vector in Q1.15 through a two-lane rotation CORDIC.
// ----------------------------------------------------------------------------
module mouse_look_direction (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [15:0] cfg_data,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // cursor_x [15:0], cursor_y [31:16]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata    // dir_x [15:0], dir_y [31:16], dir_z [47:32]
);
	import mld_pkg::*;

	logic [PC_W-1:0]   pc_q;
	ctrl_t             cw;
	logic [ITER_W-1:0] iter_q;
	logic              have_q;
	logic [15:0]       sens_q;

	logic signed [15:0] prev_x_q, prev_y_q;
	logic signed [16:0] dx_q, dy_q;
	logic [31:0]        mx_q, my_q;
	logic               neg_x_q, neg_y_q;
	logic signed [20:0] stepx_q, stepy_q;
	logic signed [20:0] yaw_q, pitch_q;

	logic signed [31:0] cx_q [2];
	logic signed [31:0] cy_q [2];
	logic signed [25:0] cz_q [2];
	logic               flip_q [2];

	logic signed [63:0] prod_q;
	logic [15:0]        dir_x_q;
	logic               m_valid_q;
	logic [47:0]        m_data_q;

	logic               in_acc, out_free;
	logic signed [15:0] in_x, in_y;
	logic [16:0]        magx, magy;
	logic [32:0]        rndx, rndy;
	logic [19:0]        satx, saty;
	logic signed [21:0] ysum, psum, ynext, pnext;
	logic signed [25:0] z0 [2];
	logic signed [31:0] xs [2];
	logic signed [31:0] ys [2];
	logic signed [25:0] at;

	function automatic logic [15:0] round_q15(input logic signed [63:0] v,
			input logic [5:0] s);
		logic [63:0] mag;
		logic [63:0] q;
		logic [15:0] r;
		mag = v[63] ? (64'd0 - 64'(v)) : 64'(v);
		q = (mag + (64'd1 << (s - 6'd1))) >> s;
		r = (q > 64'(Q15_MAX)) ? Q15_MAX : q[15:0];
		return v[63] ? (16'd0 - r) : r;
	endfunction

	assign cw        = mld_rom(pc_q);
	assign cfg_ready = 1'b1;
	assign s_tready  = (cw.op == OP_WAIT);
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;
	assign in_x      = s_tdata[15:0];
	assign in_y      = s_tdata[31:16];
	assign at        = atan_deg(iter_q);

	always_comb begin
		magx = dx_q[16] ? (17'd0 - 17'(dx_q)) : 17'(dx_q);
		magy = dy_q[16] ? (17'd0 - 17'(dy_q)) : 17'(dy_q);
		rndx = (33'(mx_q) + 33'd8) >> 4;
		rndy = (33'(my_q) + 33'd8) >> 4;
		satx = (rndx > 33'(STEP_LIMIT)) ? STEP_LIMIT : rndx[19:0];
		saty = (rndy > 33'(STEP_LIMIT)) ? STEP_LIMIT : rndy[19:0];
		ysum = 22'(yaw_q) + 22'(stepx_q);
		psum = 22'(pitch_q) + 22'(stepy_q);
		if (ysum >= YAW_HALF_TURN) begin
			ynext = ysum - YAW_FULL_TURN;
		end else if (ysum < -YAW_HALF_TURN) begin
			ynext = ysum + YAW_FULL_TURN;
		end else begin
			ynext = ysum;
		end
		if (psum > PITCH_LIMIT) begin
			pnext = PITCH_LIMIT;
		end else if (psum < -PITCH_LIMIT) begin
			pnext = -PITCH_LIMIT;
		end else begin
			pnext = psum;
		end
		z0[0] = {yaw_q[20], yaw_q, 4'b0000};
		z0[1] = {pitch_q[20], pitch_q, 4'b0000};
		for (int l = 0; l < 2; l++) begin
			xs[l] = cx_q[l] >>> iter_q;
			ys[l] = cy_q[l] >>> iter_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= PC_WAIT;
			iter_q    <= '0;
			have_q    <= 1'b0;
			sens_q    <= SENS_RESET;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			yaw_q     <= '0;
			pitch_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				sens_q <= cfg_data;
			end
			if (cw.op == OP_EMIT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (cw.cond)
				C_ALWAYS:   pc_q <= cw.target;
				C_INPUT:    if (in_acc && have_q) pc_q <= cw.target;
				C_LOOP:     pc_q <= (iter_q == ITER_W'(CORDIC_STEPS - 1)) ?
						(pc_q + 4'd1) : cw.target;
				C_OUT_FREE: if (out_free) pc_q <= cw.target;
				default:    pc_q <= PC_WAIT;
			endcase
			unique case (cw.op)
				OP_WAIT: begin
					if (in_acc) begin
						have_q   <= 1'b1;
						prev_x_q <= in_x;
						prev_y_q <= in_y;
						dx_q     <= 17'(in_x) - 17'(prev_x_q);
						dy_q     <= 17'(prev_y_q) - 17'(in_y);
					end
				end
				OP_MUL: begin
					mx_q    <= 32'(magx[15:0]) * 32'(sens_q);
					my_q    <= 32'(magy[15:0]) * 32'(sens_q);
					neg_x_q <= dx_q[16];
					neg_y_q <= dy_q[16];
				end
				OP_STEP: begin
					stepx_q <= neg_x_q ? -21'(satx) : 21'(satx);
					stepy_q <= neg_y_q ? -21'(saty) : 21'(saty);
				end
				OP_ANGLE: begin
					yaw_q   <= ynext[20:0];
					pitch_q <= pnext[20:0];
				end
				OP_LOAD: begin
					iter_q <= '0;
					for (int l = 0; l < 2; l++) begin
						cx_q[l] <= CORDIC_START;
						cy_q[l] <= '0;
						if (z0[l] > Z_QUARTER) begin
							cz_q[l]   <= z0[l] - Z_HALF;
							flip_q[l] <= 1'b1;
						end else if (z0[l] < -Z_QUARTER) begin
							cz_q[l]   <= z0[l] + Z_HALF;
							flip_q[l] <= 1'b1;
						end else begin
							cz_q[l]   <= z0[l];
							flip_q[l] <= 1'b0;
						end
					end
				end
				OP_ITER: begin
					iter_q <= iter_q + 1'b1;
					for (int l = 0; l < 2; l++) begin
						if (!cz_q[l][25]) begin
							cx_q[l] <= cx_q[l] - ys[l];
							cy_q[l] <= cy_q[l] + xs[l];
							cz_q[l] <= cz_q[l] - at;
						end else begin
							cx_q[l] <= cx_q[l] + ys[l];
							cy_q[l] <= cy_q[l] - xs[l];
							cz_q[l] <= cz_q[l] + at;
						end
					end
				end
				OP_FLIP: begin
					for (int l = 0; l < 2; l++) begin
						if (flip_q[l]) begin
							cx_q[l] <= -cx_q[l];
							cy_q[l] <= -cy_q[l];
						end
					end
				end
				OP_PROD: begin
					prod_q <= 64'(cx_q[0]) * 64'(cx_q[1]);
				end
				OP_DIRX: begin
					dir_x_q <= round_q15(prod_q, 6'd45);
					prod_q  <= 64'(cy_q[0]) * 64'(cx_q[1]);
				end
				OP_EMIT: begin
					if (out_free) begin
						m_data_q  <= {round_q15(prod_q, 6'd45),
							round_q15(64'(cy_q[1]), 6'd15), dir_x_q};
					end
				end
				default: begin
				end
			endcase
		end
	end

	a_rise_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cw.op == OP_EMIT))
		else $error("result raised outside the emit step");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		(22'(pitch_q) <= PITCH_LIMIT) && (22'(pitch_q) >= -PITCH_LIMIT))
		else $error("pitch outside its clamp");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		(22'(yaw_q) < YAW_HALF_TURN) && (22'(yaw_q) >= -YAW_HALF_TURN))
		else $error("yaw outside one turn");

	a_first_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !have_q) |=> (pc_q == PC_WAIT) && have_q)
		else $error("first item after reset started a computation");

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the mouse-look direction block
// Cursor positions stream in under random gaps and output stalls while a
// built-in camera predictor tracks yaw, pitch and the sensitivity, and every
// direction vector coming out is compared field by field with its prediction.
// ----------------------------------------------------------------------------
module testbench;

	localparam longint STEP_SAT    = 737280;
	localparam longint HALF_TURN   = 737280;
	localparam longint FULL_TURN   = 1474560;
	localparam longint PITCH_MAX   = 364544;
	localparam longint QUARTER_Z   = 90 * 65536;
	localparam longint HALF_Z      = 180 * 65536;
	localparam longint GAIN_START  = 652032874;
	localparam longint UNIT_MAX    = 32767;
	localparam int     HOLD_CYCLES = 800;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [15:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic [31:0] s_tdata   = '0;
	logic        m_tready  = 1'b0;
	logic        cfg_ready;
	logic        s_tready;
	logic        m_tvalid;
	logic [47:0] m_tdata;

	logic               view_primed = 1'b0;
	logic signed [15:0] last_x      = '0;
	logic signed [15:0] last_y      = '0;
	logic signed [20:0] yaw_q12     = '0;
	logic signed [20:0] pitch_q12   = '0;
	logic [15:0]        sens_q16    = 16'd6554;

	logic [31:0] cursor_queue[$];
	logic [47:0] dir_due[$];
	int          positions_queued = 0;
	int          positions_taken  = 0;
	int          errors           = 0;
	int          gap_left         = 0;
	int          stall_left       = 0;
	int          hold_left        = 0;
	int          k_axis;
	logic [47:0] want_dir;
	logic        send_burst = 1'b0;
	logic        recv_burst = 1'b0;
	logic        hold_req   = 1'b0;
	logic        hold_seen  = 1'b0;
	string       axis_names = "xyz";

	mouse_look_direction u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	function automatic longint arctan_q16(input int i);
		case (i)
			0:  return 2949120;
			1:  return 1740967;
			2:  return 919879;
			3:  return 466945;
			4:  return 234379;
			5:  return 117304;
			6:  return 58666;
			7:  return 29335;
			8:  return 14668;
			9:  return 7334;
			10: return 3667;
			11: return 1833;
			12: return 917;
			13: return 458;
			14: return 229;
			default: return 115;
		endcase
	endfunction

	function automatic longint turn_step(input longint delta);
		longint mag;
		longint sens;
		longint q;
		sens = sens_q16;
		mag = (delta < 0) ? -delta : delta;
		q = (mag * sens + 8) >>> 4;
		if (q > STEP_SAT) begin
			q = STEP_SAT;
		end
		return (delta < 0) ? -q : q;
	endfunction

	function automatic logic [15:0] q15_round(input longint v, input int sh);
		longint mag;
		longint q;
		mag = (v < 0) ? -v : v;
		q = (mag + (longint'(1) << (sh - 1))) >>> sh;
		if (q > UNIT_MAX) begin
			q = UNIT_MAX;
		end
		q = (v < 0) ? -q : q;
		return q[15:0];
	endfunction

	// Angle in Q9.12 degrees; sine and cosine come back in Q2.30.
	function automatic void rotate(input longint angle, output longint s, output longint c);
		longint z;
		longint x;
		longint y;
		longint nx;
		bit     flip;
		z = angle * 16;
		x = GAIN_START;
		y = 0;
		flip = 1'b0;
		if (z > QUARTER_Z) begin
			z -= HALF_Z;
			flip = 1'b1;
		end else if (z < -QUARTER_Z) begin
			z += HALF_Z;
			flip = 1'b1;
		end
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= arctan_q16(i);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += arctan_q16(i);
			end
			x = nx;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic void take_position(input logic [31:0] word);
		logic signed [15:0] px;
		logic signed [15:0] py;
		longint             yaw;
		longint             pitch;
		longint             sin_yaw;
		longint             cos_yaw;
		longint             sin_pitch;
		longint             cos_pitch;
		px = word[15:0];
		py = word[31:16];
		if (!view_primed) begin
			view_primed = 1'b1;
			last_x = px;
			last_y = py;
			return;
		end
		yaw = longint'(yaw_q12) + turn_step(longint'(px) - longint'(last_x));
		pitch = longint'(pitch_q12) + turn_step(longint'(last_y) - longint'(py));
		last_x = px;
		last_y = py;
		if (yaw >= HALF_TURN) begin
			yaw -= FULL_TURN;
		end else if (yaw < -HALF_TURN) begin
			yaw += FULL_TURN;
		end
		if (pitch > PITCH_MAX) begin
			pitch = PITCH_MAX;
		end else if (pitch < -PITCH_MAX) begin
			pitch = -PITCH_MAX;
		end
		yaw_q12 = yaw[20:0];
		pitch_q12 = pitch[20:0];
		rotate(yaw, sin_yaw, cos_yaw);
		rotate(pitch, sin_pitch, cos_pitch);
		dir_due.push_back({q15_round(sin_yaw * cos_pitch, 45), q15_round(sin_pitch, 15),
			q15_round(cos_yaw * cos_pitch, 45)});
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("testbench failed");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				take_position(s_tdata);
				positions_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (cursor_queue.size() != 0) begin
					s_tdata <= cursor_queue.pop_front();
					s_tvalid <= 1'b1;
					gap_left = send_burst ? 0 : $urandom_range(0, 5);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
			hold_seen = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (dir_due.size() == 0) begin
					$display("%0t: unexpected direction, expected none, got %h", $time, m_tdata);
					errors++;
				end else begin
					want_dir = dir_due.pop_front();
					for (k_axis = 0; k_axis < 3; k_axis++) begin
						if (m_tdata[16*k_axis +: 16] !== want_dir[16*k_axis +: 16]) begin
							$display("%0t: dir_%c expected %0d, got %0d", $time,
								axis_names[k_axis], $signed(want_dir[16*k_axis +: 16]),
								$signed(m_tdata[16*k_axis +: 16]));
							errors++;
						end
					end
				end
				stall_left = recv_burst ? 0 : $urandom_range(0, 5);
			end
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic queue_position(input logic signed [15:0] x, input logic signed [15:0] y);
		cursor_queue.push_back({y, x});
		positions_queued++;
	endtask

	task automatic write_sensitivity(input logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sens_q16 = value;
		cfg_valid <= 1'b0;
	endtask

	// The first position after reset gives no result and pushes nothing onto the
	// due queue; a trailing wait follows once both queues have drained.
	task automatic wait_idle();
		do @(posedge clk); while (positions_taken != positions_queued || dir_due.size() != 0);
		repeat (30) @(posedge clk);
	endtask

	initial begin
		logic [15:0]        sens_plan[9];
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		int                 dx;
		int                 dy;
		sens_plan = '{16'd0, 16'd65535, 16'd1, 16'd6554, 16'd256, 16'd4096, 16'd40000,
			16'($urandom), 16'($urandom)};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		queue_position(16'sd0, 16'sd0);
		queue_position(16'sd0, 16'sd0);
		queue_position(16'sd1, 16'sd0);
		queue_position(16'sd0, -16'sd1);
		queue_position(-16'sd1, 16'sd1);
		queue_position(16'sd100, -16'sd100);
		queue_position(16'sd32767, 16'sd32767);
		queue_position(-16'sd32768, -16'sd32768);
		queue_position(-16'sd32768, -16'sd32768);
		queue_position(16'sd32767, 16'sd32767);
		queue_position(-16'sd32768, -16'sd32768);
		queue_position(-16'sd1, -16'sd1);
		queue_position(16'sd16384, -16'sd16384);
		queue_position(-16'sd16384, 16'sd16384);
		queue_position(16'sd0, 16'sd0);
		queue_position(-16'sd32768, 16'sd32767);
		queue_position(16'sd32767, -16'sd32768);
		queue_position(16'sd900, 16'sd450);
		queue_position(-16'sd900, -16'sd450);
		queue_position(16'sd0, 16'sd0);
		wait_idle();

		pos_x = '0;
		pos_y = '0;
		for (int phase = 0; phase < 9; phase++) begin
			write_sensitivity(sens_plan[phase]);
			send_burst <= (phase % 2 == 0);
			recv_burst <= (phase % 3 == 0);
			if (phase == 4) begin
				hold_req <= ~hold_req;
			end
			for (int n = 0; n < 200; n++) begin
				dx = 0;
				dy = 0;
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: begin
						dx = int'($urandom_range(0, 128)) - 64;
						dy = int'($urandom_range(0, 128)) - 64;
					end
					6, 7: begin
						dx = int'($urandom_range(0, 4000)) - 2000;
						dy = int'($urandom_range(0, 4000)) - 2000;
					end
					8: begin
						pos_x = 16'($urandom);
						pos_y = 16'($urandom);
					end
					default: begin
					end
				endcase
				pos_x = 16'(pos_x + dx);
				pos_y = 16'(pos_y + dy);
				queue_position(pos_x, pos_y);
			end
			wait_idle();
		end

		if (errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
